// ===== hdl/wfbc_pkg.sv =====
// Package for the wide float to binary32 converter.
// Holds the input class codes, field widths and format constants.
// No dependencies.
package wfbc_pkg;

  localparam int unsigned WIDE_W  = 64;
  localparam int unsigned WEXP_W  = 32;
  localparam int unsigned WFRAC_W = 31;
  localparam int unsigned SGL_W   = 32;
  localparam int unsigned SEXP_W  = 8;
  localparam int unsigned SFRAC_W = 23;
  localparam int unsigned SHAMT_W = 5;

  typedef enum logic [2:0] {
    CLS_NORMAL    = 3'd0,
    CLS_SUBNORMAL = 3'd1,
    CLS_ZERO      = 3'd2,
    CLS_INF       = 3'd3,
    CLS_NAN       = 3'd4
  } in_class_t;

  // Biased wide exponent thresholds (bias 2^31-1)
  localparam logic [WEXP_W-1:0] WEXP_OVF_MAX  = 32'h8000_007E; // e = 127
  localparam logic [WEXP_W-1:0] WEXP_NORM_MIN = 32'h7FFF_FF81; // e = -126
  localparam logic [WEXP_W-1:0] WEXP_SUB_MIN  = 32'h7FFF_FF6A; // e = -149

  localparam logic [SEXP_W-1:0]  SEXP_REBIAS = 8'h80;
  localparam logic [SEXP_W-1:0]  SEXP_ONES   = 8'hFF;
  localparam logic [SHAMT_W-1:0] SHAMT_BASE  = 5'd9;
  localparam logic [SFRAC_W-1:0] SFRAC_MIN   = 23'd1;

endpackage

// ===== hdl/wfbc_in_if.sv =====
// Input channel of the wide float to binary32 converter.
// Carries valid, ready and the 64-bit wide float word.
// Depends on wfbc_pkg.
interface wfbc_in_if;
  import wfbc_pkg::*;

  logic              valid;
  logic              ready;
  logic [WIDE_W-1:0] wide_word;

  modport source (output valid, output wide_word, input ready);
  modport sink   (input valid, input wide_word, output ready);
endinterface

// ===== hdl/wfbc_out_if.sv =====
// Result channel of the wide float to binary32 converter.
// Carries valid, ready, the binary32 word and the input class.
// Depends on wfbc_pkg.
interface wfbc_out_if;
  import wfbc_pkg::*;

  logic             valid;
  logic             ready;
  logic [SGL_W-1:0] single_word;
  in_class_t        input_class;

  modport source (output valid, output single_word, output input_class, input ready);
  modport sink   (input valid, input single_word, input input_class, output ready);
endinterface

// ===== hdl/wfbc_convert.sv =====
// Combinational narrowing of one wide float word to binary32.
// Classifies, rebiases, denormalizes and rounds away from zero.
// Depends on wfbc_pkg.
module wfbc_convert (
  input  logic [wfbc_pkg::WIDE_W-1:0] wide_word,
  output logic [wfbc_pkg::SGL_W-1:0]  single_word,
  output wfbc_pkg::in_class_t         input_class
);
  import wfbc_pkg::*;

  logic                   sign;
  logic [WEXP_W-1:0]      wexp;
  logic [WFRAC_W-1:0]     wfrac;
  logic                   frac_nz;
  logic [WFRAC_W:0]       sig;
  logic [SHAMT_W-1:0]     shamt;
  logic [WFRAC_W:0]       sig_sh;
  logic [WFRAC_W:0]       sticky_mask;
  logic                   sticky;
  logic [SEXP_W-1:0]      expo;
  logic [SFRAC_W-1:0]     frac;
  logic                   rnd;
  logic [SEXP_W+SFRAC_W-1:0] mag;

  assign sign    = wide_word[WIDE_W-1];
  assign wexp    = wide_word[WFRAC_W +: WEXP_W];
  assign wfrac   = wide_word[WFRAC_W-1:0];
  assign frac_nz = |wfrac;

  assign sig         = {1'b1, wfrac};
  assign shamt       = SHAMT_BASE - wexp[SHAMT_W-1:0];
  assign sig_sh      = sig >> shamt;
  assign sticky_mask = ~({(WFRAC_W+1){1'b1}} << shamt);
  assign sticky      = |(sig & sticky_mask);

  always_comb begin
    expo        = '0;
    frac        = '0;
    rnd         = 1'b0;
    input_class = CLS_NORMAL;
    if (wexp == '0) begin
      input_class = frac_nz ? CLS_SUBNORMAL : CLS_ZERO;
      frac        = frac_nz ? SFRAC_MIN : '0;
    end else if (wexp == '1) begin
      input_class = frac_nz ? CLS_NAN : CLS_INF;
      expo        = SEXP_ONES;
      frac        = wfrac[WFRAC_W-1 -: SFRAC_W];
    end else if (wexp > WEXP_OVF_MAX) begin
      expo = SEXP_ONES;
    end else if (wexp >= WEXP_NORM_MIN) begin
      expo = wexp[SEXP_W-1:0] + SEXP_REBIAS;
      frac = wfrac[WFRAC_W-1 -: SFRAC_W];
      rnd  = |wfrac[WFRAC_W-SFRAC_W-1:0];
    end else if (wexp >= WEXP_SUB_MIN) begin
      frac = sig_sh[SFRAC_W-1:0];
      rnd  = sticky;
    end else begin
      frac = SFRAC_MIN;
    end
  end

  assign mag         = {expo, frac} + {{(SEXP_W+SFRAC_W-1){1'b0}}, rnd};
  assign single_word = {sign, mag};

endmodule

// ===== hdl/wide_float_to_binary32_converter_core.sv =====
// Wide float to binary32 converter, top level.
// Path from input transfer to result valid: input register, then result register.
// Throughput: one item per cycle unless stalled; the result register frees on its transfer.
// Reset: synchronous active-low rst_n clears both valid flags; payload registers hold.
// Depends on wfbc_pkg, wfbc_in_if, wfbc_out_if and wfbc_convert.
module wide_float_to_binary32_converter_core (
  input  logic       clk,
  input  logic       rst_n,
  wfbc_in_if.sink    in_ch,
  wfbc_out_if.source out_ch
);
  import wfbc_pkg::*;

  logic              s1_valid_r;
  logic              s1_valid_nxt;
  logic [WIDE_W-1:0] s1_word_r;
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic [SGL_W-1:0]  out_word_r;
  in_class_t         out_class_r;
  logic [SGL_W-1:0]  conv_word;
  in_class_t         conv_class;
  logic              out_adv;
  logic              s1_adv;

  wfbc_convert u_convert (
    .wide_word   (s1_word_r),
    .single_word (conv_word),
    .input_class (conv_class)
  );

  assign out_adv       = !out_valid_r || out_ch.ready;
  assign s1_adv        = !s1_valid_r || out_adv;
  assign in_ch.ready   = s1_adv;
  assign s1_valid_nxt  = s1_adv ? in_ch.valid : s1_valid_r;
  assign out_valid_nxt = out_adv ? s1_valid_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && in_ch.valid) begin
      s1_word_r <= in_ch.wide_word;
    end
    if (out_adv && s1_valid_r) begin
      out_word_r  <= conv_word;
      out_class_r <= conv_class;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.single_word = out_word_r;
  assign out_ch.input_class = out_class_r;

endmodule

// ===== verif/tb_wide_float_to_binary32_converter_core.sv =====
`timescale 1ns / 100ps
// Testbench for wide_float_to_binary32_converter_core: directed and random wide floats,
// each result checked against a built-in narrowing predictor under varied idling.
// Depends on wfbc_pkg, wfbc_in_if, wfbc_out_if and the converter core.
module tb_wide_float_to_binary32_converter_core;
  import wfbc_pkg::*;

  localparam longint WIDE_BIAS        = 64'sd2147483647;
  localparam int     RANDOM_PER_PHASE = 170;
  localparam int     DRAIN_CYCLES     = 10;

  typedef struct packed {
    logic [SGL_W-1:0] single_word;
    in_class_t        input_class;
  } binary32_result_t;

  logic clk = 1'b0;
  logic rst_n;

  wfbc_in_if  in_ch ();
  wfbc_out_if out_ch ();

  wide_float_to_binary32_converter_core uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  logic [WIDE_W-1:0] wide_pending[$];
  binary32_result_t  expected_binary32[$];
  binary32_result_t  want;
  int unsigned       src_idle_pct = 0;
  int unsigned       sink_stall_pct = 0;
  logic              hold_off;
  int                fail_cnt = 0;
  int                accepted_cnt = 0;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  initial begin
    rst_n           = 1'b0;
    hold_off        = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.wide_word = '0;
    out_ch.ready    = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
  end

  function automatic binary32_result_t narrow_to_binary32(input logic [WIDE_W-1:0] w);
    logic [WEXP_W-1:0]  wexp;
    logic [WFRAC_W-1:0] wfrac;
    logic [SEXP_W-1:0]  expo;
    logic [SFRAC_W-1:0] frac;
    logic [63:0]        sig;
    logic               sticky;
    longint             e;
    int                 sh;
    binary32_result_t   r;
    wexp   = w[62:31];
    wfrac  = w[30:0];
    expo   = '0;
    frac   = '0;
    sticky = 1'b0;
    if (wexp == '0) begin
      r.input_class = (wfrac == '0) ? CLS_ZERO : CLS_SUBNORMAL;
      frac = {22'd0, |wfrac};
    end else if (&wexp) begin
      r.input_class = (wfrac == '0) ? CLS_INF : CLS_NAN;
      expo = '1;
      frac = wfrac[30:8];
    end else begin
      r.input_class = CLS_NORMAL;
      e = $signed({32'd0, wexp}) - WIDE_BIAS;
      if (e > 127) begin
        expo = '1;
      end else if (e >= -126) begin
        expo   = 8'(e + 127);
        frac   = wfrac[30:8];
        sticky = |wfrac[7:0];
      end else if (e >= -149) begin
        sh     = 8 - int'(e + 126);
        sig    = {32'd0, 1'b1, wfrac};
        frac   = 23'(sig >> sh);
        sticky = |(sig & ((64'd1 << sh) - 64'd1));
      end else begin
        frac = 23'd1;
      end
    end
    // round away from zero; a fraction carry moves into the exponent
    if (sticky) {expo, frac} = {expo, frac} + 31'd1;
    r.single_word = {w[63], expo, frac};
    return r;
  endfunction

  function automatic logic [WEXP_W-1:0] biased(input longint e);
    return 32'(WIDE_BIAS + e);
  endfunction

  function automatic logic [WIDE_W-1:0] pack_wide(input logic s, input logic [WEXP_W-1:0] x,
                                                  input logic [WFRAC_W-1:0] f);
    return {s, x, f};
  endfunction

  function automatic logic [WIDE_W-1:0] random_wide();
    logic [WFRAC_W-1:0] f;
    logic [WEXP_W-1:0]  x;
    logic               s;
    s = 1'($urandom);
    f = 31'($urandom);
    case ($urandom_range(3))
      0: f[7:0] = '0;
      1: f = '1;
      default: ;
    endcase
    case ($urandom_range(9))
      0, 1: return {$urandom, $urandom};
      2, 3, 4: x = biased(longint'($urandom_range(253)) - 126);
      5, 6: x = biased(longint'($urandom_range(22)) - 149);
      7: begin
        case ($urandom_range(7))
          0: x = biased(-151);
          1: x = biased(-150);
          2: x = biased(-149);
          3: x = biased(-127);
          4: x = biased(-126);
          5: x = biased(127);
          6: x = biased(128);
          default: x = biased(129);
        endcase
      end
      8: x = $urandom_range(1) ? '1 : '0;
      default: x = $urandom_range(1) ? biased(128 + longint'($urandom_range(1000)))
                                     : biased(-150 - longint'($urandom_range(1000)));
    endcase
    return pack_wide(s, x, f);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_binary32.push_back(narrow_to_binary32(in_ch.wide_word));
        accepted_cnt++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (wide_pending.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          in_ch.valid     <= 1'b1;
          in_ch.wide_word <= wide_pending.pop_front();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_binary32.size() == 0) begin
          $error("unexpected transfer: single_word %h input_class %0d",
                 out_ch.single_word, out_ch.input_class);
          fail_cnt++;
        end else begin
          want = expected_binary32.pop_front();
          if (out_ch.single_word !== want.single_word) begin
            $error("single_word: expected %h, actual %h", want.single_word, out_ch.single_word);
            fail_cnt++;
          end
          if (out_ch.input_class !== want.input_class) begin
            $error("input_class: expected %0d, actual %0d", want.input_class,
                   out_ch.input_class);
            fail_cnt++;
          end
        end
      end
      out_ch.ready <= !hold_off && ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // long receiver hold-off while the sender keeps offering at full rate
  initial begin
    wait (accepted_cnt >= 60);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (80) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    #2_000_000;
    $display("tb_wide_float_to_binary32_converter_core failed");
    $finish;
  end

  initial begin
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 69; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 69; end
        default: begin src_idle_pct = 38; sink_stall_pct = 38; end
      endcase
      if (ph == 0) begin
        wide_pending.push_back(pack_wide(1'b0, '0, '0));
        wide_pending.push_back(pack_wide(1'b1, '0, '0));
        wide_pending.push_back(pack_wide(1'b0, '0, 31'd1));
        wide_pending.push_back(pack_wide(1'b1, '0, '1));
        wide_pending.push_back(pack_wide(1'b0, '1, '0));
        wide_pending.push_back(pack_wide(1'b1, '1, '0));
        wide_pending.push_back(pack_wide(1'b0, '1, 31'h4000_0000));
        wide_pending.push_back(pack_wide(1'b1, '1, 31'h0000_00FF));
        wide_pending.push_back(pack_wide(1'b0, '1, '1));
        wide_pending.push_back(pack_wide(1'b0, biased(128), 31'h1234_5678));
        wide_pending.push_back(pack_wide(1'b1, 32'hFFFF_FFFE, '0));
        wide_pending.push_back(pack_wide(1'b0, biased(127), '1));
        wide_pending.push_back(pack_wide(1'b1, biased(127), 31'h7FFF_FF00));
        wide_pending.push_back(pack_wide(1'b0, biased(0), '0));
        wide_pending.push_back(pack_wide(1'b1, biased(0), 31'd1));
        wide_pending.push_back(pack_wide(1'b0, biased(-126), '0));
        wide_pending.push_back(pack_wide(1'b1, biased(-127), '1));
        wide_pending.push_back(pack_wide(1'b0, biased(-127), '0));
        wide_pending.push_back(pack_wide(1'b0, biased(-149), '0));
        wide_pending.push_back(pack_wide(1'b1, biased(-149), '1));
        wide_pending.push_back(pack_wide(1'b0, biased(-150), 31'h2AAA_AAAA));
        wide_pending.push_back(pack_wide(1'b1, 32'd1, 31'h5555_5555));
        wide_pending.push_back('1);
        wide_pending.push_back(pack_wide(1'b0, biased(-140), 31'h2AAA_AAAA));
        wide_pending.push_back(pack_wide(1'b1, biased(1), 31'h5555_5555));
      end
      repeat (RANDOM_PER_PHASE) wide_pending.push_back(random_wide());
      // hold the sender until every result of this phase has arrived
      while (wide_pending.size() != 0 || in_ch.valid) @(negedge clk);
      while (expected_binary32.size() != 0) @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("tb_wide_float_to_binary32_converter_core passed");
    end else begin
      $display("tb_wide_float_to_binary32_converter_core failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/wfbc_pkg.sv
hdl/wfbc_in_if.sv
hdl/wfbc_out_if.sv
hdl/wfbc_convert.sv
hdl/wide_float_to_binary32_converter_core.sv
verif/tb_wide_float_to_binary32_converter_core.sv
